>>> rtl/sorted_list_insert_find_macros.svh
// Assertion macros used by the sorted list top level.
// No dependencies; included by the top level, which carries concurrent checks.
`ifndef SORTED_LIST_INSERT_FIND_MACROS_SVH
`define SORTED_LIST_INSERT_FIND_MACROS_SVH

// Check that a condition implies a property in the same cycle.
`define SLIF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a property in the following cycle.
`define SLIF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slif_pkg.sv
// Shared types and constants of the sorted list block.
// No dependencies; used by the cell and the top level.
package slif_pkg;

    localparam int VALUE_W      = 32;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // What one cell shows its right-hand neighbor and the top level
    typedef struct packed {
        logic               valid;
        logic               take;
        logic               match;
        logic               take_edge;
        logic               match_edge;
        logic [VALUE_W-1:0] value;
    } slif_link_t;

endpackage

>>> rtl/sorted_list_insert_find.sv
// Sorted list top level: a row of CAPACITY cells that compare and shift together.
// Results are registered: a result appears in the cycle after its input beat is accepted.
// One beat per cycle while results drain; all cells compare and shift at once.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
`include "sorted_list_insert_find_macros.svh"

module sorted_list_insert_find #(
    parameter int CAPACITY = slif_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [5:2] position, [10:6] entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    slif_pkg::slif_link_t                links [CAPACITY];
    slif_pkg::slif_link_t                head_link;
    logic [CAPACITY-1:0]                 valid_vec;
    logic [CAPACITY-1:0]                 match_vec;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [slif_pkg::STATUS_W-1:0]       status_reg;
    logic [slif_pkg::STATUS_W-1:0]       status_next;
    logic [slif_pkg::POS_W-1:0]          position_reg;
    logic [slif_pkg::POS_W-1:0]          position_next;
    logic [slif_pkg::COUNT_W-1:0]        entry_count_reg;
    logic [IDX_W-1:0]                    pos_idx;
    logic                                s_fire;
    logic                                full;
    logic                                insert_en;
    logic                                found;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign full      = links[CAPACITY-1].valid;
    assign insert_en = s_fire && (s_tuser == slif_pkg::OP_INSERT) && !full;

    // Boundary link ahead of the first cell: never takes, never matches
    assign head_link = '{valid: 1'b1, take: 1'b0, match: 1'b0,
                         take_edge: 1'b0, match_edge: 1'b0, value: '0};

    // Build the row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        slif_pkg::slif_link_t prev;
        if (i == 0) begin : g_head
            assign prev = head_link;
        end else begin : g_body
            assign prev = links[i-1];
        end
        slif_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .insert_en  (insert_en),
            .item_value (s_tdata),
            .prev_link  (prev),
            .link       (links[i])
        );
        assign valid_vec[i] = links[i].valid;
        assign match_vec[i] = links[i].match_edge;
    end

    // Encode the one-hot boundary of the selected operation into an index
    always_comb begin
        pos_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (s_tuser == slif_pkg::OP_INSERT) begin
                if (links[i].take_edge) begin
                    pos_idx = pos_idx | IDX_W'(i);
                end
            end else begin
                if (links[i].match_edge) begin
                    pos_idx = pos_idx | IDX_W'(i);
                end
            end
        end
    end

    assign found      = |match_vec;
    assign count_next = insert_en ? CNT_W'(count_reg + 1'b1) : count_reg;

    // Form the result of the accepted beat
    always_comb begin
        if (s_tuser == slif_pkg::OP_INSERT) begin
            if (full) begin
                status_next   = slif_pkg::ST_REJECTED;
                position_next = '0;
            end else begin
                status_next   = slif_pkg::ST_INSERTED;
                position_next = slif_pkg::POS_W'(pos_idx);
            end
        end else begin
            if (found) begin
                status_next   = slif_pkg::ST_FOUND;
                position_next = slif_pkg::POS_W'(pos_idx);
            end else begin
                status_next   = slif_pkg::ST_NOT_FOUND;
                position_next = '0;
            end
        end
    end

    // Hold the result until taken; load a new one on every accepted beat
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg      <= status_next;
            position_reg    <= position_next;
            entry_count_reg <= slif_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, entry_count_reg, position_reg, status_reg};

    // Checks on the row and the count
    `SLIF_ASSERT_SAME(a_count_matches_valid, aclk, aresetn, 1'b1,
        $countones(valid_vec) == count_reg, "valid cells disagree with count")
    `SLIF_ASSERT_NEXT(a_insert_grows, aclk, aresetn, insert_en,
        count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow count")
    `SLIF_ASSERT_SAME(a_reject_only_full, aclk, aresetn,
        m_valid_reg && (status_reg == slif_pkg::ST_REJECTED),
        count_reg == CNT_W'(CAPACITY), "rejected insert while list not full")
    `SLIF_ASSERT_SAME(a_single_first_match, aclk, aresetn, 1'b1,
        $onehot0(match_vec), "more than one first match in the row")

endmodule

>>> rtl/slif_cell.sv
// One storage cell of the sorted list row: holds one entry and its valid bit.
// Depends on slif_pkg for the link struct and the value width.
module slif_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         insert_en,
    input  logic [slif_pkg::VALUE_W-1:0] item_value,
    input  slif_pkg::slif_link_t         prev_link,
    output slif_pkg::slif_link_t         link
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [slif_pkg::VALUE_W-1:0] value_reg;
    logic [slif_pkg::VALUE_W-1:0] value_next;
    logic                         take;
    logic                         match;

    // Compare the item against the held entry; empty cells always take
    assign take  = !valid_reg || ($signed(item_value) <= $signed(value_reg));
    assign match = valid_reg && (value_reg == item_value);

    assign link.valid      = valid_reg;
    assign link.take       = take;
    assign link.match      = match;
    assign link.take_edge  = take && !prev_link.take;
    assign link.match_edge = match && !prev_link.match;
    assign link.value      = value_reg;

    // Shift from the left neighbor, load the new item at the boundary, else hold
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (insert_en) begin
            if (prev_link.take) begin
                valid_next = prev_link.valid;
                value_next = prev_link.value;
            end else if (take) begin
                valid_next = 1'b1;
                value_next = item_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

>>> bench/sorted_list_insert_find_test.sv
// Self-checking bench for sorted_list_insert_find: random insert and find beats against a
// scoreboard class that keeps its own sorted copy of the list.
// Depends on slif_pkg for field widths, opcodes and status codes.
module sorted_list_insert_find_test;
    import slif_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AFTER   = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } list_answer_t;

    // Sorted copy of the list plus the answers still owed by the block
    class list_scoreboard;
        logic signed [VALUE_W-1:0] slots [LIST_DEPTH];
        int                        fill;
        list_answer_t              answers [$];
        int unsigned               mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted beat to the sorted copy and queue its answer
        function void note_input(logic op, logic [VALUE_W-1:0] value);
            list_answer_t ans;
            int           at;
            int           i;
            bit           hit;
            ans.position = '0;
            hit          = 1'b0;
            if (op == OP_INSERT) begin
                if (fill >= LIST_DEPTH) begin
                    ans.status = ST_REJECTED;
                end else begin
                    // place before the first entry that is greater or equal
                    at = fill;
                    for (i = 0; i < fill; i++) begin
                        if (!hit && $signed(value) <= slots[i]) begin
                            at  = i;
                            hit = 1'b1;
                        end
                    end
                    for (i = fill; i > at; i--) begin
                        slots[i] = slots[i-1];
                    end
                    slots[at]    = value;
                    fill         = fill + 1;
                    ans.status   = ST_INSERTED;
                    ans.position = at[POS_W-1:0];
                end
            end else begin
                // report the first matching entry
                ans.status = ST_NOT_FOUND;
                for (i = 0; i < fill; i++) begin
                    if (!hit && slots[i] == $signed(value)) begin
                        hit          = 1'b1;
                        ans.status   = ST_FOUND;
                        ans.position = i[POS_W-1:0];
                    end
                end
            end
            ans.entry_count = fill[COUNT_W-1:0];
            answers.push_back(ans);
        endfunction

        function void flag(string what);
            if (mismatches < 10) begin
                $display("[%0t] result mismatch: %s", $time, what);
            end
            mismatches++;
        endfunction

        // Compare one result beat with the oldest owed answer
        function void check_result(logic [15:0] data);
            list_answer_t want;
            logic [STATUS_W-1:0] got_status;
            logic [POS_W-1:0]    got_position;
            logic [COUNT_W-1:0]  got_count;
            got_status   = data[1:0];
            got_position = data[5:2];
            got_count    = data[10:6];
            if (answers.size() == 0) begin
                flag($sformatf("unexpected beat status=%0d position=%0d count=%0d",
                               got_status, got_position, got_count));
                return;
            end
            want = answers.pop_front();
            if (got_status != want.status || got_position != want.position ||
                got_count != want.entry_count) begin
                flag($sformatf("expected status=%0d position=%0d count=%0d, got %0d %0d %0d",
                               want.status, want.position, want.entry_count,
                               got_status, got_position, got_count));
            end
        endfunction

        function logic [VALUE_W-1:0] pick_stored();
            if (fill == 0) begin
                return $urandom;
            end
            return slots[$urandom_range(0, fill - 1)];
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;

    list_scoreboard board = new();
    bit             quiet      = 1'b0;
    bit             hold_done  = 1'b0;
    int unsigned    items_sent = 0;

    sorted_list_insert_find dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offer one beat, hold it until accepted, then maybe idle with noise on the bus
    task automatic send_item(input logic op, input logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(op, value);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Favor duplicates and small values so equal keys land in the list
    function automatic logic [31:0] insert_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return board.pick_stored();
            3:       return extreme_value();
            4:       return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Mostly hits, some near misses, some arbitrary probes
    function automatic logic [31:0] find_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return board.pick_stored();
            5, 6:          return board.pick_stored() +
                                  ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            7:             return extreme_value();
            default:       return $urandom;
        endcase
    endfunction

    // Check every result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    // Result side: random stall bursts plus one long hold-off to back up the input
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int  n;
        logic op;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty find, extremes at head and tail, equal keys
        send_item(OP_FIND,   32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_FIND,   32'h0000_0000);
        send_item(OP_FIND,   32'h7FFF_FFFF);
        send_item(OP_FIND,   32'h8000_0000);
        send_item(OP_FIND,   32'h0000_0001);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_FIND,   32'hFFFF_FFFF);
        send_item(OP_FIND,   32'h7FFF_FFFE);
        send_item(OP_FIND,   32'h8000_0001);

        // Random: fill the list, then keep probing and hitting the full case
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
            op = ($urandom_range(0, 9) < 3) ? OP_INSERT : OP_FIND;
            send_item(op, (op == OP_INSERT) ? insert_value() : find_value());
        end
        s_tvalid <= 1'b0;

        // Drain and let any stray beat show up
        while (board.answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.answers.size() == 0) begin
            $display("sorted_list_insert_find regression: pass");
        end else begin
            $display("sorted_list_insert_find regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 200000);
        $display("sorted_list_insert_find regression: fail");
        $finish;
    end

endmodule
